// ===== sv/ple_pkg.sv =====
// Package for the positional list engine: request and status codes, FSM states, control buses.
package ple_pkg;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_READ   = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_SEARCH = 3'd4,
        REQ_UPDATE = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_REQ   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ADR_POSM1,
        ADR_IDX,
        ADR_IDXM1,
        ADR_IDXP1
    } t_addr_sel;

    typedef enum logic {
        WR_VALUE,
        WR_SHIFT
    } t_wsel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POSM1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic      latch;
        logic      mem_rd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        t_wsel     wsel;
        t_idx_op   idx_op;
        t_cnt_op   cnt_op;
        logic      res_we;
        t_status   res_status;
        logic      res_rd;
        logic      res_found;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic pos_ok;
        logic pos_ok_ins;
        logic full;
        logic ins_more;
        logic del_more;
        logic srch_more;
        logic match;
    } t_stat;

endpackage

// ===== sv/ple_dp.sv =====
// Datapath of the positional list engine: entry memory, count, index and result registers.
module ple_dp #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ple_pkg::t_cmd      i_cmd,
    input  logic [2:0]         i_req_type,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_item_value,
    output ple_pkg::t_stat     o_stat,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [7:0]         o_found_position,
    output logic [7:0]         o_element_count
);
    import ple_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

    logic signed [31:0] mem [DEPTH];

    logic [2:0]         r_req;
    logic [7:0]         r_pos;
    logic signed [31:0] r_val;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      n_idx;
    logic signed [31:0] r_rdata;
    t_status            r_status;
    logic signed [31:0] r_rd_value;
    logic [7:0]         r_found;

    logic [CMPW-1:0]    pos_w;
    logic [CMPW-1:0]    cnt_w;
    logic [CMPW-1:0]    idx_w;
    logic [CMPW-1:0]    addr_w;
    logic [AW-1:0]      addr;
    logic signed [31:0] wdata;

    assign pos_w = CMPW'(r_pos);
    assign cnt_w = CMPW'(r_count);
    assign idx_w = CMPW'(r_idx);

    always_comb begin
        case (i_cmd.addr_sel)
            ADR_POSM1: addr_w = pos_w - CMPW'(1);
            ADR_IDX:   addr_w = idx_w;
            ADR_IDXM1: addr_w = idx_w - CMPW'(1);
            ADR_IDXP1: addr_w = idx_w + CMPW'(1);
            default:   addr_w = idx_w;
        endcase
    end

    assign addr  = addr_w[AW-1:0];
    assign wdata = (i_cmd.wsel == WR_SHIFT) ? r_rdata : r_val;

    always_comb begin
        case (i_cmd.idx_op)
            IDX_COUNT: n_idx = r_count;
            IDX_POSM1: n_idx = CW'(pos_w - CMPW'(1));
            IDX_ZERO:  n_idx = '0;
            IDX_INC:   n_idx = CW'(idx_w + CMPW'(1));
            IDX_DEC:   n_idx = CW'(idx_w - CMPW'(1));
            default:   n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_CLR: n_count = '0;
            CNT_INC: n_count = CW'(cnt_w + CMPW'(1));
            CNT_DEC: n_count = CW'(cnt_w - CMPW'(1));
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[addr] <= wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.latch) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (i_cmd.res_we) begin
            r_status   <= i_cmd.res_status;
            r_rd_value <= i_cmd.res_rd ? r_rdata : '0;
            r_found    <= i_cmd.res_found ? 8'(idx_w + CMPW'(1)) : '0;
        end
    end

    always_comb begin
        o_stat.req        = t_req'(r_req);
        o_stat.pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
        o_stat.pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + CMPW'(1));
        o_stat.full       = (cnt_w == CMPW'(DEPTH));
        o_stat.ins_more   = (idx_w >= pos_w);
        o_stat.del_more   = (idx_w + CMPW'(1) < cnt_w);
        o_stat.srch_more  = (idx_w < cnt_w);
        o_stat.match      = (r_rdata == r_val);
    end

    assign o_status         = r_status;
    assign o_read_value     = r_rd_value;
    assign o_found_position = r_found;
    assign o_element_count  = 8'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_w <= CMPW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
        (r_count == $past(r_count) + 1) || (r_count == $past(r_count) - 1) ||
        (r_count == '0))
        else $error("entry count moved by more than one");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.mem_rd && i_cmd.mem_wr))
        else $error("memory read and write in the same cycle");

    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> i_cmd.cnt_op != CNT_INC)
        else $error("count increment on a full list");

endmodule

// ===== sv/ple_ctrl.sv =====
// Controller FSM of the positional list engine: sequences requests over the datapath.
module ple_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  ple_pkg::t_stat i_stat,
    output ple_pkg::t_cmd  o_cmd
);
    import ple_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_stat.req)
                    REQ_CLEAR: begin
                        o_cmd.cnt_op     = CNT_CLR;
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_status = ST_OK;
                    end
                    REQ_READ: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.addr_sel = ADR_POSM1;
                            n_state        = S_READ;
                        end else begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = ST_BAD_POS;
                        end
                    end
                    REQ_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else if (!i_stat.pos_ok_ins) begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = ST_BAD_POS;
                        end else begin
                            o_cmd.idx_op = IDX_COUNT;
                            n_state      = S_INS_CHK;
                        end
                    end
                    REQ_DELETE: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.idx_op = IDX_POSM1;
                            n_state      = S_DEL_CHK;
                        end else begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = ST_BAD_POS;
                        end
                    end
                    REQ_SEARCH: begin
                        o_cmd.idx_op = IDX_ZERO;
                        n_state      = S_SRCH_CHK;
                    end
                    REQ_UPDATE: begin
                        o_cmd.res_we = 1'b1;
                        if (i_stat.pos_ok) begin
                            o_cmd.mem_wr     = 1'b1;
                            o_cmd.addr_sel   = ADR_POSM1;
                            o_cmd.wsel       = WR_VALUE;
                            o_cmd.res_status = ST_OK;
                        end else begin
                            o_cmd.res_status = ST_BAD_POS;
                        end
                    end
                    default: begin
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_status = ST_BAD_REQ;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.res_we     = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_rd     = 1'b1;
                n_state          = S_DONE;
            end
            S_INS_CHK: begin
                if (i_stat.ins_more) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = ADR_IDXM1;
                    n_state        = S_INS_WR;
                end else begin
                    o_cmd.mem_wr     = 1'b1;
                    o_cmd.addr_sel   = ADR_POSM1;
                    o_cmd.wsel       = WR_VALUE;
                    o_cmd.cnt_op     = CNT_INC;
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_DONE;
                end
            end
            S_INS_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADR_IDX;
                o_cmd.wsel     = WR_SHIFT;
                o_cmd.idx_op   = IDX_DEC;
                n_state        = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (i_stat.del_more) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = ADR_IDXP1;
                    n_state        = S_DEL_WR;
                end else begin
                    o_cmd.cnt_op     = CNT_DEC;
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_DONE;
                end
            end
            S_DEL_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADR_IDX;
                o_cmd.wsel     = WR_SHIFT;
                o_cmd.idx_op   = IDX_INC;
                n_state        = S_DEL_CHK;
            end
            S_SRCH_CHK: begin
                if (i_stat.srch_more) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = ADR_IDX;
                    n_state        = S_SRCH_CMP;
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_found  = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_SRCH_CHK;
                end
            end
            S_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/positional_list_engine.sv =====
// Top level of the positional list engine: ordered list of signed values with request port.
//
//  channel | direction | handshake          | payload
//  request | in        | i_valid / o_ready  | i_req_type, i_position, i_item_value
//  result  | out       | o_valid / i_ready  | o_status, o_read_value, o_found_position,
//          |           |                    | o_element_count
//
// One item at a time; the entry memory has a single port, so each moved or compared
// entry takes a read state, then a write or compare state.
// Clear, update and rejects go from S_EXEC straight to S_DONE; a read passes through S_READ;
// insert, delete and search loop over their check and write or compare states per entry.
// Synchronous reset empties the list; entry contents are left as they are.
// The result holds until taken; a new item is taken the cycle after that.
module positional_list_engine #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_req_type,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_item_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [7:0]         o_found_position,
    output logic [7:0]         o_element_count
);
    import ple_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ple_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_element_count  (o_element_count)
    );

endmodule
